FILE: rtl/core/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg: shared types and constants of the interleaved PWM carrier
// Mode codes, field widths and the control and status words that pass
// between the phase lanes, the spread sequencer and the top level.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int MAX_PHASES = 6;
    localparam int SWITCH_W   = 12;
    localparam int CNT_W      = 16;
    localparam int FULL_W     = 17;
    localparam int REM_W      = 3;

    localparam logic [CNT_W-1:0] RESET_PERIOD = 16'd1000;

    // Operating modes.
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_DIS  = 2'd1;
    localparam logic [1:0] MODE_CHG  = 2'd2;

    // Commands from the spread sequencer to every lane.
    typedef struct packed {
        logic              calc_steps;
        logic              calc_wrap;
        logic              calc_fold;
        logic [CNT_W-1:0]  period;
        logic [FULL_W-1:0] quo;
        logic [REM_W-1:0]  rem;
    } spread_ctrl_t;

    // Per-tick command from the merge logic to every lane.
    typedef struct packed {
        logic       step;
        logic       enable;
        logic [1:0] mode;
    } tick_ctrl_t;

    // Per-tick status from one lane.
    typedef struct packed {
        logic zero;
        logic hit_dis;
        logic hit_chg;
    } lane_stat_t;

endpackage

FILE: rtl/core/ipc_spread.sv
// ----------------------------------------------------------------------------
// ipc_spread: period register and phase spread sequencer
// Holds the carrier period and, after reset or a period write, divides twice
// the period by the phase count with a reciprocal multiplication, then steps
// the lanes through their start position calculation.
// ----------------------------------------------------------------------------
module ipc_spread #(
    parameter int PHASES = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data,
    output logic                  busy,
    output ipc_pkg::spread_ctrl_t ctrl
);
    import ipc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_STEPS = 3'd2;
    localparam logic [2:0] ST_WRAP  = 3'd3;
    localparam logic [2:0] ST_FOLD  = 3'd4;
    localparam logic [2:0] ST_REM   = 3'd5;

    localparam int                 RECIP_SH = FULL_W + 3;
    localparam int                 RECIP_W  = RECIP_SH + 1;
    localparam int                 PROD_W   = FULL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP    =
        RECIP_W'(((1 << RECIP_SH) + PHASES - 1) / PHASES);
    localparam logic [FULL_W-1:0]  PHASES_Q = FULL_W'(PHASES);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  period_reg;
    logic [FULL_W-1:0] dvd_reg;
    logic [FULL_W-1:0] quo_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [PROD_W-1:0] prod;
    logic [FULL_W-1:0] rem_full;

    assign cfg_ready = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);

    // The rounded-up reciprocal gives the exact quotient for every 17-bit
    // dividend; the remainder follows from the registered quotient.
    always_comb begin
        prod     = PROD_W'(dvd_reg) * PROD_W'(RECIP);
        rem_full = dvd_reg - quo_reg * PHASES_Q;
    end

    // Sequencer state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (cfg_valid) state_next = ST_DIV;
            ST_DIV:   state_next = ST_REM;
            ST_REM:   state_next = ST_STEPS;
            ST_STEPS: state_next = ST_WRAP;
            ST_WRAP:  state_next = ST_FOLD;
            ST_FOLD:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_DIV;
            period_reg <= RESET_PERIOD;
            dvd_reg    <= {RESET_PERIOD, 1'b0};
            quo_reg    <= '0;
            rem_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && cfg_valid) begin
                period_reg <= cfg_data;
                dvd_reg    <= {cfg_data, 1'b0};
            end else if (state_reg == ST_DIV) begin
                quo_reg <= prod[RECIP_SH +: FULL_W];
            end else if (state_reg == ST_REM) begin
                rem_reg <= rem_full[REM_W-1:0];
            end
        end
    end

    always_comb begin
        ctrl.calc_steps = (state_reg == ST_STEPS);
        ctrl.calc_wrap  = (state_reg == ST_WRAP);
        ctrl.calc_fold  = (state_reg == ST_FOLD);
        ctrl.period     = period_reg;
        ctrl.quo        = quo_reg;
        ctrl.rem        = rem_reg;
    end

endmodule

FILE: rtl/core/ipc_lane.sv
// ----------------------------------------------------------------------------
// ipc_lane: one phase of the carrier
// Triangle counter, duty stores of both modes, start position calculation
// and the duty compares for one phase.
// ----------------------------------------------------------------------------
module ipc_lane #(
    parameter int PHASES = 6,
    parameter int LANE   = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ipc_pkg::spread_ctrl_t sctl,
    input  ipc_pkg::tick_ctrl_t   tctl,
    input  logic [15:0]           duty,
    output ipc_pkg::lane_stat_t   stat
);
    import ipc_pkg::*;

    localparam logic [FULL_W-1:0] LANE_Q = FULL_W'(LANE);
    localparam logic [5:0]        LANE_R = 6'(LANE);

    logic [CNT_W-1:0]  count_reg;
    logic              down_reg;
    logic [CNT_W-1:0]  dis_duty_reg;
    logic [CNT_W-1:0]  chg_duty_reg;
    logic [FULL_W-1:0] steps_reg;
    logic [FULL_W-1:0] raw_reg;

    logic [5:0]        ir;
    logic [FULL_W-1:0] frac;
    logic [FULL_W-1:0] full;
    logic [FULL_W:0]   total;
    logic [FULL_W:0]   total_wrap;
    logic signed [FULL_W:0] cs;
    logic [CNT_W-1:0]  cnt_next;
    logic              down_next;
    logic              latch_dis;
    logic              latch_chg;
    logic [CNT_W-1:0]  eff_dis;
    logic [CNT_W-1:0]  eff_chg;

    // Start position: steps = LANE*q + floor(LANE*r / PHASES).
    // With a period of one the raw position can reach twice the full cycle,
    // so the wrap takes off the full cycle up to two times.
    always_comb begin
        ir   = 6'(sctl.rem) * LANE_R;
        frac = '0;
        for (int j = 1; j < MAX_PHASES; j++) begin
            if (j < PHASES && ir >= 6'(j * PHASES)) frac = FULL_W'(j);
        end
        full       = {sctl.period, 1'b0};
        total      = (FULL_W+1)'(sctl.period) + (FULL_W+1)'(1) + (FULL_W+1)'(full)
                     - (FULL_W+1)'(steps_reg);
        total_wrap = total;
        if (total_wrap >= (FULL_W+1)'(full)) total_wrap = total_wrap - (FULL_W+1)'(full);
        if (total_wrap >= (FULL_W+1)'(full)) total_wrap = total_wrap - (FULL_W+1)'(full);
    end

    // Carrier step with clamping at both turning points.
    always_comb begin
        cs        = $signed({2'b00, count_reg}) + (down_reg ? -18'sd1 : 18'sd1);
        cnt_next  = cs[CNT_W-1:0];
        down_next = down_reg;
        if (cs >= $signed({2'b00, sctl.period})) begin
            cnt_next  = sctl.period;
            down_next = 1'b1;
        end
        if (cs <= 18'sd0) begin
            cnt_next  = '0;
            down_next = 1'b0;
        end
    end

    // Duty latching at the valley and the compares against the new count.
    always_comb begin
        stat.zero = (cnt_next == '0);
        latch_dis = tctl.enable && stat.zero && (tctl.mode == MODE_DIS);
        latch_chg = tctl.enable && stat.zero && (tctl.mode == MODE_CHG);
        eff_dis   = latch_dis ? duty : dis_duty_reg;
        eff_chg   = latch_chg ? duty : chg_duty_reg;
        stat.hit_dis = (eff_dis >= cnt_next);
        stat.hit_chg = (eff_chg >= cnt_next);
    end

    // Spread pipeline registers.
    always_ff @(posedge aclk) begin
        if (sctl.calc_steps) steps_reg <= sctl.quo * LANE_Q + frac;
        if (sctl.calc_wrap)  raw_reg   <= total_wrap[FULL_W-1:0];
    end

    // Counter and duty stores.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            down_reg     <= 1'b0;
            dis_duty_reg <= '0;
            chg_duty_reg <= '0;
        end else begin
            if (sctl.calc_fold) begin
                if (sctl.period == '0) begin
                    count_reg <= '0;
                    down_reg  <= 1'b0;
                end else if (raw_reg <= FULL_W'(sctl.period)) begin
                    count_reg <= raw_reg[CNT_W-1:0];
                    down_reg  <= 1'b0;
                end else begin
                    count_reg <= CNT_W'(full - raw_reg);
                    down_reg  <= 1'b1;
                end
            end else if (tctl.step) begin
                count_reg <= cnt_next;
                down_reg  <= down_next;
                if (latch_dis) dis_duty_reg <= duty;
                if (latch_chg) chg_duty_reg <= duty;
            end
        end
    end

endmodule

FILE: rtl/core/interleaved_pwm_carrier.sv
// ----------------------------------------------------------------------------
// interleaved_pwm_carrier: multiphase interleaved center-aligned PWM
// Top level: phase lanes, mode merge, switch word and output buffer.
// ----------------------------------------------------------------------------
// Usage:
// Each word on the s_ channel is one PWM timer tick carrying the enable,
// the mode request and one duty count per phase. Every tick moves all phase
// carriers one step, and the m_ channel returns one word per tick with the
// switch bits and the active mode.
// The result of a tick is registered in the output buffer; with the buffer empty
// it is presented on m_ the cycle after the tick is accepted. One tick is taken
// in every cycle while s_ready is high: all phase lanes work in parallel and the
// mode merge and switch compare finish within the cycle that accepts the tick.
// A two-word output buffer lets the input take one more tick while the receiver
// stalls; with both words held, s_ready drops until m_ready.
// The period port writes the carrier half period (cfg_data) when cfg_valid and
// cfg_ready are high. After reset, and after each period write, a spread pass
// (a reciprocal multiply for the quotient by the phase count, a remainder step
// and three lane steps) sets the start positions; s_ready and cfg_ready are low
// during it. Reset sets the period to 1000 and clears duties, mode and switches.
// ----------------------------------------------------------------------------
module interleaved_pwm_carrier #(
    parameter int PHASES = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_enable,
    input  logic [1:0]  s_mode_request,
    input  logic [15:0] s_duty_a,
    input  logic [15:0] s_duty_b,
    input  logic [15:0] s_duty_c,
    input  logic [15:0] s_duty_d,
    input  logic [15:0] s_duty_e,
    input  logic [15:0] s_duty_f,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_switch_bits,
    output logic [1:0]  m_active_mode
);
    import ipc_pkg::*;

    spread_ctrl_t      sctl;
    tick_ctrl_t        tctl;
    lane_stat_t        stat [MAX_PHASES];
    logic [15:0]       duty_in [MAX_PHASES];
    logic              busy;
    logic              push;
    logic              pop;
    logic              any_zero;
    logic [1:0]        mode_next;
    logic [SWITCH_W-1:0] sw_built;
    logic [SWITCH_W-1:0] sw_next;

    logic [1:0]          mode_reg;
    logic [SWITCH_W-1:0] switch_reg;
    logic [1:0]          fill_reg;
    logic [SWITCH_W-1:0] head_sw_reg, tail_sw_reg;
    logic [1:0]          head_mode_reg, tail_mode_reg;

    assign duty_in[0] = s_duty_a;
    assign duty_in[1] = s_duty_b;
    assign duty_in[2] = s_duty_c;
    assign duty_in[3] = s_duty_d;
    assign duty_in[4] = s_duty_e;
    assign duty_in[5] = s_duty_f;

    ipc_spread #(.PHASES(PHASES)) u_spread (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .ctrl      (sctl)
    );

    // Phase lanes; phases past PHASES report nothing.
    for (genvar i = 0; i < MAX_PHASES; i++) begin : g_lane
        if (i < PHASES) begin : g_on
            ipc_lane #(.PHASES(PHASES), .LANE(i)) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .sctl    (sctl),
                .tctl    (tctl),
                .duty    (duty_in[i]),
                .stat    (stat[i])
            );
        end else begin : g_off
            assign stat[i] = '0;
        end
    end

    // Handshakes.
    assign s_ready = !busy && (fill_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop     = m_valid && m_ready;

    // Merge: an enabled mode request takes effect when any phase sits at the valley.
    always_comb begin
        any_zero = 1'b0;
        for (int i = 0; i < MAX_PHASES; i++) any_zero = any_zero | stat[i].zero;
        mode_next = mode_reg;
        if (s_enable && any_zero
            && (s_mode_request == MODE_DIS || s_mode_request == MODE_CHG)) begin
            mode_next = s_mode_request;
        end
        tctl.step   = push;
        tctl.enable = s_enable;
        tctl.mode   = mode_next;
    end

    // Switch word from the lane compares.
    always_comb begin
        sw_built = '0;
        for (int i = 0; i < MAX_PHASES; i++) begin
            sw_built[2*i]   = (mode_next == MODE_DIS) && stat[i].hit_dis;
            sw_built[2*i+1] = (mode_next == MODE_CHG) && stat[i].hit_chg;
        end
        sw_next = switch_reg;
        if (s_enable && (mode_next == MODE_DIS || mode_next == MODE_CHG)) begin
            sw_next = sw_built;
        end
    end

    // Mode and switch state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_NONE;
            switch_reg <= '0;
        end else if (push) begin
            mode_reg   <= mode_next;
            switch_reg <= sw_next;
        end
    end

    // Two-word output buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10: fill_reg <= fill_reg + 2'd1;
                2'b01: fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b10: begin
                if (fill_reg == 2'd0) begin
                    head_sw_reg   <= sw_next;
                    head_mode_reg <= mode_next;
                end else begin
                    tail_sw_reg   <= sw_next;
                    tail_mode_reg <= mode_next;
                end
            end
            2'b01: begin
                head_sw_reg   <= tail_sw_reg;
                head_mode_reg <= tail_mode_reg;
            end
            2'b11: begin
                head_sw_reg   <= sw_next;
                head_mode_reg <= mode_next;
            end
            default: begin
                head_sw_reg   <= head_sw_reg;
                head_mode_reg <= head_mode_reg;
            end
        endcase
    end

    assign m_valid       = (fill_reg != 2'd0);
    assign m_switch_bits = head_sw_reg;
    assign m_active_mode = head_mode_reg;

endmodule

FILE: dv/interleaved_pwm_carrier_tb.sv
// ----------------------------------------------------------------------------
// interleaved_pwm_carrier_tb: self-checking bench for the interleaved PWM
// Sends tick words with random gaps and output stalls, keeps its own carrier
// and duty-latch model, and compares every result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module interleaved_pwm_carrier_tb;
    import ipc_pkg::*;

    localparam int PHASES         = 6;
    localparam int MAX_IDLE       = 14;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int MAX_REPORTS    = 10;

    // Mode request codes besides the two that select a mode.
    localparam logic [1:0] REQ_KEEP     = 2'd0;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic                        enable;
        logic [1:0]                  mode_request;
        logic [MAX_PHASES-1:0][15:0] duty;
    } tick_t;

    typedef struct packed {
        logic [11:0] switch_bits;
        logic [1:0]  active_mode;
    } pwm_word_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_enable;
    logic [1:0]  s_mode_request;
    logic [15:0] s_duty_a;
    logic [15:0] s_duty_b;
    logic [15:0] s_duty_c;
    logic [15:0] s_duty_d;
    logic [15:0] s_duty_e;
    logic [15:0] s_duty_f;
    logic        m_valid;
    logic        m_ready;
    logic [11:0] m_switch_bits;
    logic [1:0]  m_active_mode;

    // Carrier and duty-latch state as the block should hold it.
    logic [15:0] period_setting;
    logic [15:0] carrier_pos     [MAX_PHASES];
    logic        carrier_falling [MAX_PHASES];
    logic [15:0] dis_duty_store  [MAX_PHASES];
    logic [15:0] chg_duty_store  [MAX_PHASES];
    logic [1:0]  mode_latched;
    logic [11:0] switch_word;

    pwm_word_t   expected_words [$];

    int          n_failures      = 0;
    int          n_words         = 0;
    int          n_ticks_sent    = 0;
    int          n_period_writes = 0;
    int          idle_cycles     = 0;
    logic        tx_idle_on      = 1'b0;
    logic        rx_idle_on      = 1'b0;
    int          rx_hold_req     = 0;

    interleaved_pwm_carrier #(
        .PHASES(PHASES)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_enable      (s_enable),
        .s_mode_request(s_mode_request),
        .s_duty_a      (s_duty_a),
        .s_duty_b      (s_duty_b),
        .s_duty_c      (s_duty_c),
        .s_duty_d      (s_duty_d),
        .s_duty_e      (s_duty_e),
        .s_duty_f      (s_duty_f),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_switch_bits (m_switch_bits),
        .m_active_mode (m_active_mode)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Carrier model
    // ------------------------------------------------------------------------

    // Place every carrier at its start position for the current period. The
    // start position wraps around the full carrier cycle and folds the far
    // half back onto the falling slope.
    function automatic void respread_carriers();
        int unsigned full;
        int unsigned steps;
        int unsigned raw;
        int          i;
        full = 2 * int'(period_setting);
        for (i = 0; i < MAX_PHASES; i++) begin
            if (period_setting == 16'd0 || i >= PHASES) begin
                carrier_pos[i]     = 16'd0;
                carrier_falling[i] = 1'b0;
            end else begin
                steps = (i * full) / PHASES;
                raw   = (int'(period_setting) + 1 + full - steps) % full;
                if (raw <= period_setting) begin
                    carrier_pos[i]     = raw[15:0];
                    carrier_falling[i] = 1'b0;
                end else begin
                    carrier_pos[i]     = 16'(full - raw);
                    carrier_falling[i] = 1'b1;
                end
            end
        end
    endfunction

    function automatic void reset_carrier_model();
        int i;
        period_setting = RESET_PERIOD;
        respread_carriers();
        for (i = 0; i < MAX_PHASES; i++) begin
            dis_duty_store[i] = 16'd0;
            chg_duty_store[i] = 16'd0;
        end
        mode_latched = MODE_NONE;
        switch_word  = '0;
    endfunction

    // Move every carrier one step, latch mode and duties at the carrier
    // valleys, and work out the switch word for this tick.
    function automatic pwm_word_t advance_tick(input tick_t t);
        pwm_word_t   w;
        logic [11:0] s;
        int          c;
        int          per;
        int          i;
        per = int'(period_setting);
        for (i = 0; i < PHASES; i++) begin
            c = int'(carrier_pos[i]) + (carrier_falling[i] ? -1 : 1);
            if (c >= per) begin
                c = per;
                carrier_falling[i] = 1'b1;
            end
            if (c <= 0) begin
                c = 0;
                carrier_falling[i] = 1'b0;
            end
            carrier_pos[i] = c[15:0];
        end
        if (t.enable) begin
            for (i = 0; i < PHASES; i++) begin
                if (carrier_pos[i] == 16'd0) begin
                    if (t.mode_request == MODE_DIS) begin
                        mode_latched = MODE_DIS;
                    end else if (t.mode_request == MODE_CHG) begin
                        mode_latched = MODE_CHG;
                    end
                    if (mode_latched == MODE_DIS) begin
                        dis_duty_store[i] = t.duty[i];
                    end else if (mode_latched == MODE_CHG) begin
                        chg_duty_store[i] = t.duty[i];
                    end
                end
            end
            // With no mode chosen yet the switches keep their last value.
            if (mode_latched == MODE_DIS || mode_latched == MODE_CHG) begin
                s = '0;
                for (i = 0; i < PHASES; i++) begin
                    if (mode_latched == MODE_DIS) begin
                        s[2*i] = (dis_duty_store[i] >= carrier_pos[i]);
                    end else begin
                        s[2*i+1] = (chg_duty_store[i] >= carrier_pos[i]);
                    end
                end
                switch_word = s;
            end
        end
        w.switch_bits = switch_word;
        w.active_mode = mode_latched;
        return w;
    endfunction

    function automatic void note_failure(input string msg);
        n_failures++;
        if (n_failures <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: tracks period writes, predicts each accepted tick and checks
    // each accepted result word against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : word_monitor
        tick_t     seen;
        pwm_word_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                period_setting = cfg_data;
                respread_carriers();
            end
            if (m_valid && m_ready) begin
                n_words++;
                if (expected_words.size() == 0) begin
                    note_failure($sformatf("result word %0d with no tick pending", n_words));
                end else begin
                    want = expected_words.pop_front();
                    if (m_switch_bits !== want.switch_bits) begin
                        note_failure($sformatf("word %0d: switch_bits expected %03h got %03h",
                                               n_words, want.switch_bits, m_switch_bits));
                    end
                    if (m_active_mode !== want.active_mode) begin
                        note_failure($sformatf("word %0d: active_mode expected %0d got %0d",
                                               n_words, want.active_mode, m_active_mode));
                    end
                end
            end
            if (s_valid && s_ready) begin
                seen.enable       = s_enable;
                seen.mode_request = s_mode_request;
                seen.duty         = {s_duty_f, s_duty_e, s_duty_d, s_duty_c, s_duty_b, s_duty_a};
                expected_words.push_back(advance_tick(seen));
            end
        end
    end

    // Watchdog: ends the run when no word moves on any channel for too long.
    always @(posedge aclk) begin
        if (aresetn && !((s_valid && s_ready) || (m_valid && m_ready) ||
                         (cfg_valid && cfg_ready))) begin
            idle_cycles <= idle_cycles + 1;
        end else begin
            idle_cycles <= 0;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("interleaved_pwm_carrier_tb NOT OK");
            $finish;
        end
    end

    // Result sink: when rx_idle_on is set, draws a random stall after each word,
    // and holds off for a long stretch whenever a test asks for one.
    initial begin : result_sink
        int unsigned rx_wait;
        int          rx_hold_seen;
        rx_wait      = 0;
        rx_hold_seen = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                rx_wait = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (rx_hold_seen != rx_hold_req) begin
                rx_hold_seen = rx_hold_req;
                rx_wait      = HOLD_CYCLES;
            end
            if (rx_wait != 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic tick_t make_tick(input logic en, input logic [1:0] req,
                                        input logic [MAX_PHASES-1:0][15:0] d);
        tick_t t;
        t.enable       = en;
        t.mode_request = req;
        t.duty         = d;
        return t;
    endfunction

    // Mostly enabled ticks that keep the mode, with duties near the carrier
    // range so the compare flips often; some full-range and extreme duties.
    function automatic tick_t random_tick(input int per);
        tick_t t;
        int    pick;
        int    lim;
        int    i;
        t.enable = ($urandom_range(0, 7) != 0);
        pick = $urandom_range(0, 15);
        if (pick < 10) begin
            t.mode_request = REQ_KEEP;
        end else if (pick < 12) begin
            t.mode_request = MODE_DIS;
        end else if (pick < 14) begin
            t.mode_request = MODE_CHG;
        end else begin
            t.mode_request = REQ_RESERVED;
        end
        lim = (per + 1 > 65535) ? 65535 : per + 1;
        for (i = 0; i < MAX_PHASES; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                t.duty[i] = 16'($urandom_range(0, lim));
            end else if (pick < 9) begin
                t.duty[i] = 16'($urandom_range(0, 65535));
            end else begin
                t.duty[i] = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            end
        end
        return t;
    endfunction

    // Offer one tick word after an optional gap and wait until it is taken.
    task automatic send_tick(input tick_t t);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_enable       <= t.enable;
        s_mode_request <= t.mode_request;
        s_duty_a       <= t.duty[0];
        s_duty_b       <= t.duty[1];
        s_duty_c       <= t.duty[2];
        s_duty_d       <= t.duty[3];
        s_duty_e       <= t.duty[4];
        s_duty_f       <= t.duty[5];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_ticks_sent++;
    endtask

    // Stop offering ticks until every predicted word has been received.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // Period writes happen only with the block drained.
    task automatic write_period(input logic [15:0] per);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_data  <= per;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        n_period_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset period: no carrier reaches a valley soon, so no mode is taken
    // and the switches must stay off whatever is requested.
    task automatic test_reset_hold();
        send_tick(make_tick(1'b0, MODE_DIS,     {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, REQ_KEEP,     '0));
        send_tick(make_tick(1'b1, REQ_RESERVED, {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, MODE_CHG,     '0));
        send_tick(make_tick(1'b1, MODE_DIS,     {3{16'hAAAA, 16'h5555}}));
    endtask

    // Unit period: every carrier hits its valley every other tick, so each
    // mode request, enable hold and duty extreme shows up at once.
    task automatic test_unit_period_modes();
        write_period(16'd1);
        send_tick(make_tick(1'b0, MODE_DIS,     {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, REQ_KEEP,     {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, REQ_RESERVED, {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, MODE_DIS,     '0));
        send_tick(make_tick(1'b1, REQ_KEEP,     {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, REQ_KEEP,     {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, MODE_CHG,     {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, REQ_KEEP,     '0));
        send_tick(make_tick(1'b0, MODE_CHG,     '0));
        send_tick(make_tick(1'b1, REQ_RESERVED, {3{16'h5555, 16'hAAAA}}));
        send_tick(make_tick(1'b1, MODE_DIS,     {3{16'hAAAA, 16'h5555}}));
        send_tick(make_tick(1'b1, REQ_KEEP,
                            {16'd0, 16'd1, 16'd2, 16'd1, 16'd0, 16'hFFFF}));
    endtask

    // Zero period: every carrier sits in its valley on every tick.
    task automatic test_zero_period();
        write_period(16'd0);
        send_tick(make_tick(1'b1, REQ_KEEP,     {6{16'h1234}}));
        send_tick(make_tick(1'b1, MODE_CHG,     '0));
        send_tick(make_tick(1'b0, MODE_DIS,     {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, MODE_DIS,     {16'd0, 16'hFFFF, 16'd0, 16'd7, 16'd0, 16'd1}));
        send_tick(make_tick(1'b1, REQ_RESERVED, {6{16'hFFFF}}));
        send_tick(make_tick(1'b1, MODE_CHG,     {3{16'hAAAA, 16'h5555}}));
    endtask

    // Random ticks over a series of periods. Small periods get most of the
    // ticks since only they bring the carriers to their valleys often.
    task automatic test_random_ticks();
        logic [15:0] periods [15];
        int          seg;
        int          n_seg_ticks;
        int unsigned idle_pick;
        periods = '{16'd2, 16'd3, 16'd5, 16'd1, 16'd7, 16'd12, 16'd4, 16'd1000,
                    16'd9, 16'd6, 16'd65535, 16'd25, 16'd3, 16'd0, 16'd11};
        for (seg = 0; seg < 15; seg++) begin
            write_period(periods[seg]);
            idle_pick  = $urandom_range(0, 3);
            tx_idle_on = idle_pick[0];
            rx_idle_on <= idle_pick[1];
            if (periods[seg] == 16'd1000 || periods[seg] == 16'd65535) begin
                n_seg_ticks = 20;
            end else if (periods[seg] == 16'd0) begin
                n_seg_ticks = 10;
            end else begin
                n_seg_ticks = $urandom_range(25, 40);
            end
            repeat (n_seg_ticks) send_tick(random_tick(int'(periods[seg])));
        end
    endtask

    // The sink holds off for a long stretch while ticks keep coming, so the
    // output buffer fills and the input stalls; then the sender pauses until
    // everything has drained.
    task automatic test_output_stall();
        write_period(16'd3);
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        rx_hold_req <= rx_hold_req + 1;
        repeat (40) send_tick(random_tick(3));
        wait_all_results();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
        repeat (15) send_tick(random_tick(3));
    endtask

    initial begin
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_enable       <= 1'b0;
        s_mode_request <= REQ_KEEP;
        s_duty_a       <= '0;
        s_duty_b       <= '0;
        s_duty_c       <= '0;
        s_duty_d       <= '0;
        s_duty_e       <= '0;
        s_duty_f       <= '0;
        reset_carrier_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_hold();
        test_unit_period_modes();
        test_zero_period();
        test_random_ticks();
        test_output_stall();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_words.size() != 0) begin
            note_failure($sformatf("%0d result words never arrived", expected_words.size()));
        end

        $display("Sent %0d ticks and checked %0d result words over %0d period writes.",
                 n_ticks_sent, n_words, n_period_writes);
        $display("Periods ran from zero to full scale, with enable holds, all mode requests "
                 , "and a long output stall.");
        if (n_failures == 0) begin
            $display("interleaved_pwm_carrier_tb OK");
        end else begin
            $display("%0d failures", n_failures);
            $display("interleaved_pwm_carrier_tb NOT OK");
        end
        $finish;
    end

endmodule

FILE: interleaved_pwm_carrier.f
rtl/core/ipc_pkg.sv
rtl/core/ipc_spread.sv
rtl/core/ipc_lane.sv
rtl/core/interleaved_pwm_carrier.sv
dv/interleaved_pwm_carrier_tb.sv
